/* rtl/assert_macros.svh */
// Assertion macros shared by the range window averaging RTL.
// Expands to concurrent assertions in simulation and to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IRWA_ASSERT_NOW(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("irwa assertion failed");
`define IRWA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("irwa assertion failed");
`else
`define IRWA_ASSERT_NOW(lbl, clk, rst_n, expr)
`define IRWA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/irwa_pkg.sv */
// Shared constants, segment tables, microcode op codes and control structs
// for the range window averaging unit. No dependencies.
package irwa_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int COUNT_BITS_DEF  = 16;

  localparam int TICK_W     = 9;
  localparam int CPV_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int DIST_W     = 8;
  localparam int MEAN_OUT_W = 10;
  localparam int SEG_W      = 3;
  localparam int BASE_W     = 19;
  localparam int DEN_W      = 19;
  localparam int NUM_W      = 26;
  localparam int DIFF_W     = 16;
  localparam int SCALE_W    = 7;
  localparam int OP_W       = 5;

  localparam logic [TICK_W-1:0] WINDOW_TICKS_RST = 9'd125;
  localparam logic [CPV_W-1:0]  CPV_RST          = 10'd202;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_VOLT = 2'd1;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic [SCALE_W-1:0] MEAN_SCALE = 7'd100;
  localparam logic [SEG_W-1:0]   SEG_FIRST  = 3'd0;
  localparam logic [SEG_W-1:0]   SEG_LAST   = 3'd7;

  // Entry 0 is the upper range limit; entries 1..7 are the segments.
  localparam logic [8:0] SEG_LO [8] = '{9'd300, 9'd250, 9'd200, 9'd150,
                                        9'd125, 9'd90, 9'd65, 9'd50};
  localparam logic [15:0] SEG_DQ [8] = '{16'd0, 16'd2000, 16'd3000, 16'd4000,
                                         16'd5000, 16'd7000, 16'd10000, 16'd42000};
  localparam logic [9:0] SEG_SLOPE [8] = '{10'd0, 10'd20, 10'd20, 10'd20,
                                           10'd40, 10'd40, 10'd120, 10'd800};
  localparam logic [8:0] SEG_DENK [8] = '{9'd100, 9'd100, 9'd100, 9'd100,
                                          9'd100, 9'd100, 9'd100, 9'd300};

  localparam logic [OP_W-1:0] OP_WAIT    = 5'd0;
  localparam logic [OP_W-1:0] OP_NOP     = 5'd1;
  localparam logic [OP_W-1:0] OP_TICK    = 5'd2;
  localparam logic [OP_W-1:0] OP_DIVLD1  = 5'd3;
  localparam logic [OP_W-1:0] OP_DIVSTEP = 5'd4;
  localparam logic [OP_W-1:0] OP_MEAN    = 5'd5;
  localparam logic [OP_W-1:0] OP_SEGINIT = 5'd6;
  localparam logic [OP_W-1:0] OP_SEGCMP  = 5'd7;
  localparam logic [OP_W-1:0] OP_SEGNEXT = 5'd8;
  localparam logic [OP_W-1:0] OP_OOR     = 5'd9;
  localparam logic [OP_W-1:0] OP_PROD    = 5'd10;
  localparam logic [OP_W-1:0] OP_NUM     = 5'd11;
  localparam logic [OP_W-1:0] OP_DIVLD2  = 5'd12;
  localparam logic [OP_W-1:0] OP_DIST    = 5'd13;
  localparam logic [OP_W-1:0] OP_EMPTY   = 5'd14;
  localparam logic [OP_W-1:0] OP_EMIT    = 5'd15;
  localparam logic [OP_W-1:0] OP_ACC     = 5'd16;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } ctrl_t;

  typedef struct packed {
    logic no_req;
    logic is_sample;
    logic tick_open;
    logic empty;
    logic loop_more;
    logic ge;
    logic seg_not_last;
    logic seg_zero;
    logic out_free;
  } status_t;

endpackage

/* rtl/ir_range_window_average_unit.sv */
// Range window averaging unit: one request at a time. A sample is accumulated; a tick advances
// the window counter, and a closing tick divides the sum by the count in the bit-serial divider,
// searches the segments one per step and divides again for the distance.
// Empty windows skip the divisions and the search; out-of-range ones emit a zero distance.
// A stalled result is retried until the output register is free, which frees the next request.
// Synchronous active-low reset clears the window state and loads window_ticks 125, cpv 202.
module ir_range_window_average_unit
  import irwa_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_cmd,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DIST_W-1:0]      out_distance_cm,
  output logic [MEAN_OUT_W-1:0]  out_mean_counts,
  output logic                   out_out_of_range,
  output logic                   out_empty_window,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  ctrl_t   ctrl;
  status_t status;

  irwa_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  irwa_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .status           (status),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_distance_cm  (out_distance_cm),
    .out_mean_counts  (out_mean_counts),
    .out_out_of_range (out_out_of_range),
    .out_empty_window (out_empty_window),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  assign cfg_ready = 1'b1;

endmodule

/* rtl/irwa_divider.sv */
// Shared restoring divider, one quotient bit per step.
// Loaded with a pre-shifted remainder and left-aligned dividend bits; uses irwa_pkg.
module irwa_divider
  import irwa_pkg::*;
#(
  parameter int DVW = 19,
  parameter int QW  = 10
) (
  input  logic           clk,
  input  logic           load,
  input  logic           step,
  input  logic [DVW-1:0] rem_init,
  input  logic [QW-1:0]  q_init,
  input  logic [DVW-1:0] divisor_in,
  output logic [QW-1:0]  quotient
);

  logic [DVW-1:0] rem_r, rem_nxt;
  logic [QW-1:0]  q_r, q_nxt;
  logic [DVW-1:0] dvs_r, dvs_nxt;
  logic [DVW:0]   trial;
  logic [DVW:0]   trial_sub;
  logic           fits;

  always_comb begin
    trial     = {rem_r, q_r[QW-1]};
    trial_sub = trial - {1'b0, dvs_r};
    fits      = trial >= {1'b0, dvs_r};
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    dvs_nxt   = dvs_r;
    if (load) begin
      rem_nxt = rem_init;
      q_nxt   = q_init;
      dvs_nxt = divisor_in;
    end else if (step) begin
      rem_nxt = fits ? trial_sub[DVW-1:0] : trial[DVW-1:0];
      q_nxt   = {q_r[QW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = q_r;

endmodule

/* rtl/irwa_datapath.sv */
// Datapath: accumulators, tick counter, segment arithmetic, config and output registers.
// Driven one op per cycle by irwa_sequencer; uses irwa_pkg and irwa_divider.
`include "assert_macros.svh"
module irwa_datapath
  import irwa_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctrl_t                  ctrl,
  output status_t                status,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_cmd,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DIST_W-1:0]      out_distance_cm,
  output logic [MEAN_OUT_W-1:0]  out_mean_counts,
  output logic                   out_out_of_range,
  output logic                   out_empty_window,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int S      = SAMPLE_BITS;
  localparam int C      = COUNT_BITS;
  localparam int SUM_W  = S + C;
  localparam int M100_W = S + SCALE_W;
  localparam int DVW    = (C > DEN_W) ? C : DEN_W;
  localparam int QW     = (S > DIST_W) ? S : DIST_W;
  localparam int LOOP_W = $clog2(QW + 1);
  localparam int MEXT_W = (S > MEAN_OUT_W) ? S : MEAN_OUT_W;
  localparam int CMP_W  = (M100_W > BASE_W) ? M100_W : BASE_W;

  logic                  cmd_r, cmd_nxt;
  logic [S-1:0]          sample_r, sample_nxt;
  logic [TICK_W-1:0]     tick_r, tick_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [C-1:0]          count_r, count_nxt;
  logic [S-1:0]          mean_r, mean_nxt;
  logic [M100_W-1:0]     m100_r, m100_nxt;
  logic [SEG_W-1:0]      seg_r, seg_nxt;
  logic [DIFF_W-1:0]     diff_r, diff_nxt;
  logic [NUM_W-1:0]      prod_a_r, prod_a_nxt;
  logic [NUM_W-1:0]      prod_s_r, prod_s_nxt;
  logic [DEN_W-1:0]      den_r, den_nxt;
  logic [NUM_W-1:0]      num_r, num_nxt;
  logic [DIST_W-1:0]     dist_r, dist_nxt;
  logic                  oor_r, oor_nxt;
  logic                  empty_r, empty_nxt;
  logic [LOOP_W-1:0]     loop_r, loop_nxt;
  logic [TICK_W-1:0]     wt_r, wt_nxt;
  logic [CPV_W-1:0]      cpv_r, cpv_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0]     out_dist_r, out_dist_nxt;
  logic [MEAN_OUT_W-1:0] out_mean_r, out_mean_nxt;
  logic                  out_oor_r, out_oor_nxt;
  logic                  out_empty_r, out_empty_nxt;

  logic [TICK_W-1:0]     wt_eff;
  logic [CPV_W-1:0]      cpv_eff;
  logic [TICK_W:0]       tick_plus;
  logic                  tick_open;
  logic [BASE_W-1:0]     base;
  logic [CMP_W-1:0]      cmp_diff;
  logic                  seg_ge;
  logic                  out_free;
  logic                  emit_fire;
  logic [MEXT_W-1:0]     mean_ext;
  logic                  div_load;
  logic                  div_step;
  logic [DVW-1:0]        div_rem_init;
  logic [QW-1:0]         div_q_init;
  logic [DVW-1:0]        div_divisor;
  logic [QW-1:0]         quotient;

  irwa_divider #(
    .DVW (DVW),
    .QW  (QW)
  ) u_div (
    .clk        (clk),
    .load       (div_load),
    .step       (div_step),
    .rem_init   (div_rem_init),
    .q_init     (div_q_init),
    .divisor_in (div_divisor),
    .quotient   (quotient)
  );

  always_comb begin
    wt_eff    = (wt_r == '0) ? TICK_W'(1) : wt_r;
    cpv_eff   = (cpv_r == '0) ? CPV_W'(1) : cpv_r;
    tick_plus = {1'b0, tick_r} + (TICK_W + 1)'(1);
    tick_open = tick_plus < {1'b0, wt_eff};
    base      = BASE_W'(SEG_LO[seg_r]) * BASE_W'(cpv_eff);
    cmp_diff  = CMP_W'(m100_r) - CMP_W'(base);
    seg_ge    = CMP_W'(m100_r) >= CMP_W'(base);
    out_free  = !out_valid_r || !out_stall;
    emit_fire = (ctrl.op == OP_EMIT) && out_free;
    mean_ext  = MEXT_W'(mean_r);

    div_load     = (ctrl.op == OP_DIVLD1) || (ctrl.op == OP_DIVLD2);
    div_step     = ctrl.op == OP_DIVSTEP;
    div_rem_init = (ctrl.op == OP_DIVLD1) ? DVW'(sum_r[SUM_W-1:S])
                                          : DVW'(num_r[NUM_W-1:DIST_W]);
    div_q_init   = (ctrl.op == OP_DIVLD1) ? (QW'(sum_r[S-1:0]) << (QW - S))
                                          : (QW'(num_r[DIST_W-1:0]) << (QW - DIST_W));
    div_divisor  = (ctrl.op == OP_DIVLD1) ? DVW'(count_r) : DVW'(den_r);

    status.no_req       = !in_valid;
    status.is_sample    = cmd_r == CMD_SAMPLE;
    status.tick_open    = tick_open;
    status.empty        = count_r == '0;
    status.loop_more    = loop_r != LOOP_W'(1);
    status.ge           = seg_ge;
    status.seg_not_last = seg_r != SEG_LAST;
    status.seg_zero     = seg_r == SEG_FIRST;
    status.out_free     = out_free;
  end

  always_comb begin
    cmd_nxt       = cmd_r;
    sample_nxt    = sample_r;
    tick_nxt      = tick_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    mean_nxt      = mean_r;
    m100_nxt      = m100_r;
    seg_nxt       = seg_r;
    diff_nxt      = diff_r;
    prod_a_nxt    = prod_a_r;
    prod_s_nxt    = prod_s_r;
    den_nxt       = den_r;
    num_nxt       = num_r;
    dist_nxt      = dist_r;
    oor_nxt       = oor_r;
    empty_nxt     = empty_r;
    loop_nxt      = loop_r;
    out_dist_nxt  = out_dist_r;
    out_mean_nxt  = out_mean_r;
    out_oor_nxt   = out_oor_r;
    out_empty_nxt = out_empty_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (ctrl.op)
      OP_WAIT: begin
        if (in_valid) begin
          cmd_nxt    = in_cmd;
          sample_nxt = in_sample;
        end
      end
      OP_NOP: begin
      end
      OP_ACC: begin
        if (!(&count_r)) begin
          sum_nxt   = sum_r + SUM_W'(sample_r);
          count_nxt = count_r + C'(1);
        end
      end
      OP_TICK: begin
        tick_nxt = tick_open ? tick_plus[TICK_W-1:0] : '0;
      end
      OP_DIVLD1: begin
        loop_nxt = LOOP_W'(S);
      end
      OP_DIVSTEP: begin
        loop_nxt = loop_r - LOOP_W'(1);
      end
      OP_MEAN: begin
        mean_nxt = quotient[S-1:0];
        m100_nxt = M100_W'(quotient[S-1:0]) * M100_W'(MEAN_SCALE);
      end
      OP_SEGINIT: begin
        seg_nxt = SEG_FIRST;
      end
      OP_SEGCMP: begin
        diff_nxt = cmp_diff[DIFF_W-1:0];
      end
      OP_SEGNEXT: begin
        seg_nxt = seg_r + SEG_W'(1);
      end
      OP_OOR: begin
        dist_nxt  = '0;
        oor_nxt   = 1'b1;
        empty_nxt = 1'b0;
      end
      OP_PROD: begin
        prod_a_nxt = NUM_W'(SEG_DQ[seg_r]) * NUM_W'(cpv_eff);
        den_nxt    = DEN_W'(SEG_DENK[seg_r]) * DEN_W'(cpv_eff);
        prod_s_nxt = NUM_W'(SEG_SLOPE[seg_r]) * NUM_W'(diff_r);
      end
      OP_NUM: begin
        num_nxt = prod_a_r - prod_s_r;
      end
      OP_DIVLD2: begin
        loop_nxt = LOOP_W'(DIST_W);
      end
      OP_DIST: begin
        dist_nxt  = quotient[DIST_W-1:0];
        oor_nxt   = 1'b0;
        empty_nxt = 1'b0;
      end
      OP_EMPTY: begin
        dist_nxt  = '0;
        mean_nxt  = '0;
        oor_nxt   = 1'b0;
        empty_nxt = 1'b1;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = dist_r;
          out_mean_nxt  = mean_ext[MEAN_OUT_W-1:0];
          out_oor_nxt   = oor_r;
          out_empty_nxt = empty_r;
          sum_nxt       = '0;
          count_nxt     = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    wt_nxt  = wt_r;
    cpv_nxt = cpv_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_WINDOW_TICKS:    wt_nxt  = cfg_wdata[TICK_W-1:0];
        REG_COUNTS_PER_VOLT: cpv_nxt = cfg_wdata[CPV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      wt_r        <= WINDOW_TICKS_RST;
      cpv_r       <= CPV_RST;
      out_valid_r <= 1'b0;
    end else begin
      tick_r      <= tick_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      wt_r        <= wt_nxt;
      cpv_r       <= cpv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    sample_r    <= sample_nxt;
    mean_r      <= mean_nxt;
    m100_r      <= m100_nxt;
    seg_r       <= seg_nxt;
    diff_r      <= diff_nxt;
    prod_a_r    <= prod_a_nxt;
    prod_s_r    <= prod_s_nxt;
    den_r       <= den_nxt;
    num_r       <= num_nxt;
    dist_r      <= dist_nxt;
    oor_r       <= oor_nxt;
    empty_r     <= empty_nxt;
    loop_r      <= loop_nxt;
    out_dist_r  <= out_dist_nxt;
    out_mean_r  <= out_mean_nxt;
    out_oor_r   <= out_oor_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign in_stall         = ctrl.op != OP_WAIT;
  assign out_valid        = out_valid_r;
  assign out_distance_cm  = out_dist_r;
  assign out_mean_counts  = out_mean_r;
  assign out_out_of_range = out_oor_r;
  assign out_empty_window = out_empty_r;

  `IRWA_ASSERT_NEXT(a_emit_clears_window, clk, rst_n, emit_fire, (sum_r == '0) && (count_r == '0))
  `IRWA_ASSERT_NOW(a_oor_zero_distance, clk, rst_n, !(out_valid_r && out_oor_r) || (out_dist_r == '0))
  `IRWA_ASSERT_NOW(a_empty_clean, clk, rst_n, !(out_valid_r && out_empty_r) || ((out_dist_r == '0) && (out_mean_r == '0) && !out_oor_r))
  `IRWA_ASSERT_NOW(a_acc_on_sample, clk, rst_n, (ctrl.op != OP_ACC) || (cmd_r == CMD_SAMPLE))

endmodule

/* rtl/irwa_sequencer.sv */
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Issues one datapath op per cycle; uses irwa_pkg.
module irwa_sequencer
  import irwa_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  status_t status,
  output ctrl_t   ctrl
);

  localparam int PC_W   = 5;
  localparam int COND_W = 4;

  localparam logic [COND_W-1:0] C_NEVER        = 4'd0;
  localparam logic [COND_W-1:0] C_ALWAYS       = 4'd1;
  localparam logic [COND_W-1:0] C_NO_REQ       = 4'd2;
  localparam logic [COND_W-1:0] C_IS_SAMPLE    = 4'd3;
  localparam logic [COND_W-1:0] C_TICK_OPEN    = 4'd4;
  localparam logic [COND_W-1:0] C_EMPTY        = 4'd5;
  localparam logic [COND_W-1:0] C_LOOP         = 4'd6;
  localparam logic [COND_W-1:0] C_GE           = 4'd7;
  localparam logic [COND_W-1:0] C_SEG_NOT_LAST = 4'd8;
  localparam logic [COND_W-1:0] C_SEG_ZERO     = 4'd9;
  localparam logic [COND_W-1:0] C_OUT_FREE     = 4'd10;

  localparam logic [PC_W-1:0] A_WAIT     = 5'd0;
  localparam logic [PC_W-1:0] A_DISP     = 5'd1;
  localparam logic [PC_W-1:0] A_TICK     = 5'd2;
  localparam logic [PC_W-1:0] A_DIVLD1   = 5'd3;
  localparam logic [PC_W-1:0] A_DIVLOOP1 = 5'd4;
  localparam logic [PC_W-1:0] A_MEAN     = 5'd5;
  localparam logic [PC_W-1:0] A_SEGINIT  = 5'd6;
  localparam logic [PC_W-1:0] A_SEGCMP   = 5'd7;
  localparam logic [PC_W-1:0] A_SEGNEXT  = 5'd8;
  localparam logic [PC_W-1:0] A_OOR      = 5'd9;
  localparam logic [PC_W-1:0] A_PROD     = 5'd10;
  localparam logic [PC_W-1:0] A_NUM      = 5'd11;
  localparam logic [PC_W-1:0] A_DIVLD2   = 5'd12;
  localparam logic [PC_W-1:0] A_DIVLOOP2 = 5'd13;
  localparam logic [PC_W-1:0] A_DIST     = 5'd14;
  localparam logic [PC_W-1:0] A_EMPTY    = 5'd15;
  localparam logic [PC_W-1:0] A_EMIT     = 5'd16;
  localparam logic [PC_W-1:0] A_RETRY    = 5'd17;
  localparam logic [PC_W-1:0] A_ACC      = 5'd18;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } ucode_t;

  function automatic ucode_t rom_word(input logic [PC_W-1:0] addr);
    ucode_t w;
    unique case (addr)
      A_WAIT:     w = '{op: OP_WAIT,    cond: C_NO_REQ,       target: A_WAIT};
      A_DISP:     w = '{op: OP_NOP,     cond: C_IS_SAMPLE,    target: A_ACC};
      A_TICK:     w = '{op: OP_TICK,    cond: C_TICK_OPEN,    target: A_WAIT};
      A_DIVLD1:   w = '{op: OP_DIVLD1,  cond: C_EMPTY,        target: A_EMPTY};
      A_DIVLOOP1: w = '{op: OP_DIVSTEP, cond: C_LOOP,         target: A_DIVLOOP1};
      A_MEAN:     w = '{op: OP_MEAN,    cond: C_NEVER,        target: A_WAIT};
      A_SEGINIT:  w = '{op: OP_SEGINIT, cond: C_NEVER,        target: A_WAIT};
      A_SEGCMP:   w = '{op: OP_SEGCMP,  cond: C_GE,           target: A_PROD};
      A_SEGNEXT:  w = '{op: OP_SEGNEXT, cond: C_SEG_NOT_LAST, target: A_SEGCMP};
      A_OOR:      w = '{op: OP_OOR,     cond: C_ALWAYS,       target: A_EMIT};
      A_PROD:     w = '{op: OP_PROD,    cond: C_SEG_ZERO,     target: A_OOR};
      A_NUM:      w = '{op: OP_NUM,     cond: C_NEVER,        target: A_WAIT};
      A_DIVLD2:   w = '{op: OP_DIVLD2,  cond: C_NEVER,        target: A_WAIT};
      A_DIVLOOP2: w = '{op: OP_DIVSTEP, cond: C_LOOP,         target: A_DIVLOOP2};
      A_DIST:     w = '{op: OP_DIST,    cond: C_ALWAYS,       target: A_EMIT};
      A_EMPTY:    w = '{op: OP_EMPTY,   cond: C_NEVER,        target: A_WAIT};
      A_EMIT:     w = '{op: OP_EMIT,    cond: C_OUT_FREE,     target: A_WAIT};
      A_RETRY:    w = '{op: OP_NOP,     cond: C_ALWAYS,       target: A_EMIT};
      A_ACC:      w = '{op: OP_ACC,     cond: C_ALWAYS,       target: A_WAIT};
      default:    w = '{op: OP_NOP,     cond: C_ALWAYS,       target: A_WAIT};
    endcase
    return w;
  endfunction

  logic [PC_W-1:0] pc_r, pc_nxt;
  ucode_t          word;
  logic            take;

  always_comb begin
    word = rom_word(pc_r);
    unique case (word.cond)
      C_NEVER:        take = 1'b0;
      C_ALWAYS:       take = 1'b1;
      C_NO_REQ:       take = status.no_req;
      C_IS_SAMPLE:    take = status.is_sample;
      C_TICK_OPEN:    take = status.tick_open;
      C_EMPTY:        take = status.empty;
      C_LOOP:         take = status.loop_more;
      C_GE:           take = status.ge;
      C_SEG_NOT_LAST: take = status.seg_not_last;
      C_SEG_ZERO:     take = status.seg_zero;
      C_OUT_FREE:     take = status.out_free;
      default:        take = 1'b0;
    endcase
    pc_nxt  = take ? word.target : pc_r + PC_W'(1);
    ctrl.op = word.op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= A_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule
